// File: rtl/nsc_pkg.sv
// Shared types, constants and helper functions for the NMEA sentence checker.
package nsc_pkg;

    localparam int LINE_LIMIT = 128;
    localparam int POS_W      = $clog2(LINE_LIMIT + 1);
    localparam int SUM_W      = POS_W + 1;
    localparam int FIELD_W    = 7;
    localparam int FIELD_MAX  = (1 << FIELD_W) - 1;
    localparam int TAG_LEN    = 5;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_DOLLAR,
        PH_BODY,
        PH_HEX,
        PH_DONE,
        PH_BROKEN
    } phase_t;

    typedef enum logic [2:0] {
        FAIL_OK         = 3'd0,
        FAIL_NO_PREFIX  = 3'd1,
        FAIL_NO_DOLLAR  = 3'd2,
        FAIL_UNTERM     = 3'd3,
        FAIL_ZERO_SUM   = 3'd4,
        FAIL_MISMATCH   = 3'd5
    } fail_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    // Character expected at each place of the "+IPD," tag.
    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_PLUS;
            3'd1:    c = CH_I;
            3'd2:    c = CH_P;
            3'd3:    c = CH_D;
            default: c = CH_COMMA;
        endcase
        return c;
    endfunction

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.valid = 1'b0;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.valid = 1'b1;
            h.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            h.valid = 1'b1;
            h.value = 4'(c - 8'h61 + 8'd10);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            h.valid = 1'b1;
            h.value = 4'(c - 8'h41 + 8'd10);
        end
        return h;
    endfunction

    // Clamp a position or count to the width of an output field.
    function automatic logic [FIELD_W-1:0] sat_field(input logic [SUM_W-1:0] v);
        logic [FIELD_W-1:0] r;
        if (v > SUM_W'(FIELD_MAX)) begin
            r = FIELD_W'(FIELD_MAX);
        end
        else begin
            r = v[FIELD_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/nmea_sentence_checker.sv
// Top level of the NMEA sentence checker: byte-wise line scan with one result per line.
//
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------------------
//  line    | line_valid / line_stall    | line_byte, line_last
//  result  | result_valid / result_stall| sentence_ok, fail_code, sums, field spans
//
// One byte is accepted per cycle while line_stall is low. Each byte waits in the input register
// and is folded into the line state when it advances; the result register is loaded on
// that same edge, so a line's result is registered together with the fold of its last byte.
// Reset clears the line state and both valid flags. While a result waits under
// result_stall, further bytes that are not the last of a line still flow; only a
// line end stalls the input until the result register is free.
module nmea_sentence_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         line_valid,
    output logic                         line_stall,
    input  logic [7:0]                   line_byte,
    input  logic                         line_last,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         sentence_ok,
    output logic [2:0]                   fail_code,
    output logic [7:0]                   computed_sum,
    output logic [7:0]                   received_sum,
    output logic [nsc_pkg::FIELD_W-1:0]  name_offset,
    output logic [nsc_pkg::FIELD_W-1:0]  name_length,
    output logic                         detail_present,
    output logic [nsc_pkg::FIELD_W-1:0]  detail_offset,
    output logic [nsc_pkg::FIELD_W-1:0]  detail_length
);

    // Input register.
    logic                           hold_valid_reg;
    logic [7:0]                     byte_reg;
    logic                           last_reg;

    // Line state.
    nsc_pkg::phase_t                phase_reg, phase_next;
    logic [2:0]                     matched_reg, matched_next;
    logic [nsc_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [7:0]                     xor_reg, xor_next;
    logic [7:0]                     hex_reg, hex_next;
    logic [nsc_pkg::FIELD_W-1:0]    name_begin_reg, name_begin_next;
    logic [nsc_pkg::FIELD_W-1:0]    name_count_reg, name_count_next;
    logic                           comma_reg, comma_next;
    logic [nsc_pkg::FIELD_W-1:0]    detail_begin_reg, detail_begin_next;
    logic [nsc_pkg::FIELD_W-1:0]    detail_count_reg, detail_count_next;
    logic                           overlong_reg, overlong_next;

    // Result register.
    logic                           res_valid_reg;
    logic                           res_ok_reg;
    nsc_pkg::fail_t                 res_code_reg, res_code_next;
    logic [7:0]                     res_xor_reg;
    logic [7:0]                     res_hex_reg;
    logic [nsc_pkg::FIELD_W-1:0]    res_name_off_reg;
    logic [nsc_pkg::FIELD_W-1:0]    res_name_len_reg;
    logic                           res_comma_reg;
    logic [nsc_pkg::FIELD_W-1:0]    res_det_off_reg;
    logic [nsc_pkg::FIELD_W-1:0]    res_det_len_reg;

    logic                           res_free;
    logic                           advance;
    logic                           finish;
    logic                           take;
    logic                           line_accept;
    logic                           is_break;
    nsc_pkg::hex_t                  digit;
    logic [nsc_pkg::SUM_W-1:0]      pos_plus;

    assign res_free    = !res_valid_reg || !result_stall;
    assign advance     = hold_valid_reg && (!last_reg || res_free);
    assign finish      = advance && last_reg;
    assign take        = advance && (pos_reg < nsc_pkg::POS_W'(nsc_pkg::LINE_LIMIT));
    assign line_stall  = hold_valid_reg && !advance;
    assign line_accept = line_valid && !line_stall;

    assign is_break = (byte_reg == nsc_pkg::CH_CR) || (byte_reg == nsc_pkg::CH_LF)
                   || (byte_reg == nsc_pkg::CH_NUL);
    assign digit    = nsc_pkg::hex_decode(byte_reg);
    assign pos_plus = nsc_pkg::SUM_W'(pos_reg) + nsc_pkg::SUM_W'(1);

    // Phase of the line scan after the held byte.
    always_comb
    begin
        phase_next = phase_reg;
        if (take) begin
            case (phase_reg)
                nsc_pkg::PH_PREFIX:
                begin
                    if (byte_reg == nsc_pkg::tag_char(matched_reg)
                        && matched_reg == 3'(nsc_pkg::TAG_LEN - 1)) begin
                        phase_next = nsc_pkg::PH_DOLLAR;
                    end
                end
                nsc_pkg::PH_DOLLAR:
                begin
                    if (byte_reg == nsc_pkg::CH_DOLLAR) begin
                        phase_next = nsc_pkg::PH_BODY;
                    end
                end
                nsc_pkg::PH_BODY:
                begin
                    if (byte_reg == nsc_pkg::CH_STAR) begin
                        phase_next = nsc_pkg::PH_HEX;
                    end
                    else if (is_break) begin
                        phase_next = nsc_pkg::PH_BROKEN;
                    end
                end
                nsc_pkg::PH_HEX:
                begin
                    if (!digit.valid) begin
                        phase_next = nsc_pkg::PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Datapath updates of the line state.
    always_comb
    begin
        matched_next      = matched_reg;
        pos_next          = pos_reg;
        xor_next          = xor_reg;
        hex_next          = hex_reg;
        name_begin_next   = name_begin_reg;
        name_count_next   = name_count_reg;
        comma_next        = comma_reg;
        detail_begin_next = detail_begin_reg;
        detail_count_next = detail_count_reg;
        overlong_next     = overlong_reg;

        if (advance && !take) begin
            overlong_next = 1'b1;
        end
        if (take) begin
            pos_next = pos_plus[nsc_pkg::POS_W-1:0];
            case (phase_reg)
                nsc_pkg::PH_PREFIX:
                begin
                    if (byte_reg == nsc_pkg::tag_char(matched_reg)) begin
                        matched_next = matched_reg + 3'd1;
                    end
                    else begin
                        matched_next = (byte_reg == nsc_pkg::CH_PLUS) ? 3'd1 : 3'd0;
                    end
                end
                nsc_pkg::PH_DOLLAR:
                begin
                    if (byte_reg == nsc_pkg::CH_DOLLAR) begin
                        name_begin_next = nsc_pkg::sat_field(pos_plus);
                    end
                end
                nsc_pkg::PH_BODY:
                begin
                    if (byte_reg != nsc_pkg::CH_STAR && !is_break) begin
                        xor_next = xor_reg ^ byte_reg;
                        if (comma_reg) begin
                            detail_count_next = nsc_pkg::sat_field(
                                nsc_pkg::SUM_W'(detail_count_reg) + nsc_pkg::SUM_W'(1));
                        end
                        else if (byte_reg == nsc_pkg::CH_COMMA) begin
                            comma_next        = 1'b1;
                            detail_begin_next = nsc_pkg::sat_field(pos_plus);
                        end
                        else begin
                            name_count_next = nsc_pkg::sat_field(
                                nsc_pkg::SUM_W'(name_count_reg) + nsc_pkg::SUM_W'(1));
                        end
                    end
                end
                nsc_pkg::PH_HEX:
                begin
                    if (digit.valid) begin
                        hex_next = {hex_reg[3:0], digit.value};
                    end
                end
                default:
                begin
                    matched_next = matched_reg;
                end
            endcase
        end
    end

    // Verdict of the line, taken from the state that includes its last byte.
    always_comb
    begin
        if (overlong_next) begin
            res_code_next = nsc_pkg::FAIL_UNTERM;
        end
        else begin
            case (phase_next)
                nsc_pkg::PH_PREFIX: res_code_next = nsc_pkg::FAIL_NO_PREFIX;
                nsc_pkg::PH_DOLLAR: res_code_next = nsc_pkg::FAIL_NO_DOLLAR;
                nsc_pkg::PH_BODY:   res_code_next = nsc_pkg::FAIL_UNTERM;
                nsc_pkg::PH_BROKEN: res_code_next = nsc_pkg::FAIL_UNTERM;
                default:
                begin
                    if (xor_next == 8'd0) begin
                        res_code_next = nsc_pkg::FAIL_ZERO_SUM;
                    end
                    else if (hex_next != xor_next) begin
                        res_code_next = nsc_pkg::FAIL_MISMATCH;
                    end
                    else begin
                        res_code_next = nsc_pkg::FAIL_OK;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
        end
        else if (line_accept) begin
            hold_valid_reg <= 1'b1;
        end
        else if (advance) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_accept) begin
            byte_reg <= line_byte;
            last_reg <= line_last;
        end
    end

    // The line state returns to its reset value after the last byte of a line.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= nsc_pkg::PH_PREFIX;
            matched_reg      <= 3'd0;
            pos_reg          <= '0;
            xor_reg          <= 8'd0;
            hex_reg          <= 8'd0;
            name_begin_reg   <= '0;
            name_count_reg   <= '0;
            comma_reg        <= 1'b0;
            detail_begin_reg <= '0;
            detail_count_reg <= '0;
            overlong_reg     <= 1'b0;
        end
        else if (finish) begin
            phase_reg        <= nsc_pkg::PH_PREFIX;
            matched_reg      <= 3'd0;
            pos_reg          <= '0;
            xor_reg          <= 8'd0;
            hex_reg          <= 8'd0;
            name_begin_reg   <= '0;
            name_count_reg   <= '0;
            comma_reg        <= 1'b0;
            detail_begin_reg <= '0;
            detail_count_reg <= '0;
            overlong_reg     <= 1'b0;
        end
        else begin
            phase_reg        <= phase_next;
            matched_reg      <= matched_next;
            pos_reg          <= pos_next;
            xor_reg          <= xor_next;
            hex_reg          <= hex_next;
            name_begin_reg   <= name_begin_next;
            name_count_reg   <= name_count_next;
            comma_reg        <= comma_next;
            detail_begin_reg <= detail_begin_next;
            detail_count_reg <= detail_count_next;
            overlong_reg     <= overlong_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end
        else if (finish) begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish) begin
            res_ok_reg       <= (res_code_next == nsc_pkg::FAIL_OK);
            res_code_reg     <= res_code_next;
            res_xor_reg      <= xor_next;
            res_hex_reg      <= hex_next;
            res_name_off_reg <= name_begin_next;
            res_name_len_reg <= name_count_next;
            res_comma_reg    <= comma_next;
            res_det_off_reg  <= comma_next ? detail_begin_next : '0;
            res_det_len_reg  <= comma_next ? detail_count_next : '0;
        end
    end

    assign result_valid   = res_valid_reg;
    assign sentence_ok    = res_ok_reg;
    assign fail_code      = res_code_reg;
    assign computed_sum   = res_xor_reg;
    assign received_sum   = res_hex_reg;
    assign name_offset    = res_name_off_reg;
    assign name_length    = res_name_len_reg;
    assign detail_present = res_comma_reg;
    assign detail_offset  = res_det_off_reg;
    assign detail_length  = res_det_len_reg;

endmodule

// File: rtl/nsc_checker.sv
// Port-level assertions for the NMEA sentence checker and their bind.
module nsc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         result_valid,
    input logic                         result_stall,
    input logic                         sentence_ok,
    input logic [2:0]                   fail_code,
    input logic [7:0]                   computed_sum,
    input logic [7:0]                   received_sum,
    input logic [nsc_pkg::FIELD_W-1:0]  name_offset,
    input logic                         detail_present,
    input logic [nsc_pkg::FIELD_W-1:0]  detail_offset,
    input logic [nsc_pkg::FIELD_W-1:0]  detail_length
);

    // A result that waits under stall keeps its verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(fail_code)
            && $stable(computed_sum) && $stable(received_sum))
        else $error("stalled result changed");

    // The pass flag agrees with the failure code.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (sentence_ok == (fail_code == nsc_pkg::FAIL_OK)))
        else $error("sentence_ok disagrees with fail_code");

    // A passing sentence has a nonzero checksum that matches.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && sentence_ok |-> computed_sum != 8'd0
            && computed_sum == received_sum)
        else $error("passing sentence with bad checksum");

    // Without a comma the detail span reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !detail_present |-> detail_offset == '0 && detail_length == '0)
        else $error("detail span without comma");

    // A line without the prefix gathers nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && fail_code == nsc_pkg::FAIL_NO_PREFIX
            |-> computed_sum == 8'd0 && name_offset == '0 && !detail_present)
        else $error("fields gathered before prefix");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .sentence_ok    (sentence_ok),
    .fail_code      (fail_code),
    .computed_sum   (computed_sum),
    .received_sum   (received_sum),
    .name_offset    (name_offset),
    .detail_present (detail_present),
    .detail_offset  (detail_offset),
    .detail_length  (detail_length)
);

// File: tb/sv/tb_nmea_sentence_checker.sv
// Self-checking testbench for the NMEA sentence checker: directed lines, then random lines.
module tb_nmea_sentence_checker;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOW_LIMIT  = 10;

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        logic                         ok;
        nsc_pkg::fail_t               code;
        logic [7:0]                   csum;
        logic [7:0]                   rsum;
        logic [nsc_pkg::FIELD_W-1:0]  noff;
        logic [nsc_pkg::FIELD_W-1:0]  nlen;
        logic                         dpres;
        logic [nsc_pkg::FIELD_W-1:0]  doff;
        logic [nsc_pkg::FIELD_W-1:0]  dlen;
    } verdict_t;

    // One directed line: head, then fill copies of 'A', then tail.
    // In the text, '~' stands for byte 0xFF and '#' for a NUL byte.
    typedef struct {
        string          head;
        int             fill;
        string          tail;
        bit             typed;
        nsc_pkg::fail_t code;
    } case_row_t;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         line_valid   = 1'b0;
    logic [7:0]                   line_byte    = 8'h00;
    logic                         line_last    = 1'b0;
    logic                         result_stall = 1'b0;
    logic                         line_stall;
    logic                         result_valid;
    logic                         sentence_ok;
    logic [2:0]                   fail_code;
    logic [7:0]                   computed_sum;
    logic [7:0]                   received_sum;
    logic [nsc_pkg::FIELD_W-1:0]  name_offset;
    logic [nsc_pkg::FIELD_W-1:0]  name_length;
    logic                         detail_present;
    logic [nsc_pkg::FIELD_W-1:0]  detail_offset;
    logic [nsc_pkg::FIELD_W-1:0]  detail_length;

    nmea_sentence_checker DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .line_valid     (line_valid),
        .line_stall     (line_stall),
        .line_byte      (line_byte),
        .line_last      (line_last),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .sentence_ok    (sentence_ok),
        .fail_code      (fail_code),
        .computed_sum   (computed_sum),
        .received_sum   (received_sum),
        .name_offset    (name_offset),
        .name_length    (name_length),
        .detail_present (detail_present),
        .detail_offset  (detail_offset),
        .detail_length  (detail_length)
    );

    always #5 clk = ~clk;

    case_row_t directed_rows [25] = '{
        '{"~",                      0,   "",    1'b1, nsc_pkg::FAIL_NO_PREFIX},
        '{"#",                      0,   "",    1'b1, nsc_pkg::FAIL_NO_PREFIX},
        '{"+IPD,",                  0,   "",    1'b1, nsc_pkg::FAIL_NO_DOLLAR},
        '{"$A*41+IPD,",             0,   "",    1'b1, nsc_pkg::FAIL_NO_DOLLAR},
        '{"+IPD,$GPGGA",            0,   "",    1'b1, nsc_pkg::FAIL_UNTERM},
        '{"+IPD,$GP\015GA*12",      0,   "",    1'b1, nsc_pkg::FAIL_UNTERM},
        '{"+IPD,$GP\nX*00",         0,   "",    1'b1, nsc_pkg::FAIL_UNTERM},
        '{"+IPD,$GP#X*00",          0,   "",    1'b1, nsc_pkg::FAIL_UNTERM},
        '{"+IPD,$AA*00",            0,   "",    1'b1, nsc_pkg::FAIL_ZERO_SUM},
        '{"+IPD,$AA*",              0,   "",    1'b1, nsc_pkg::FAIL_ZERO_SUM},
        '{"+IPD,$A*41",             0,   "",    1'b1, nsc_pkg::FAIL_OK},
        '{"+IPD,$A*42",             0,   "",    1'b1, nsc_pkg::FAIL_MISMATCH},
        '{"+IPD,$a*61\015\n",       0,   "",    1'b1, nsc_pkg::FAIL_OK},
        '{"xx+IP+IPD,$B*42",        0,   "",    1'b1, nsc_pkg::FAIL_OK},
        '{"++IPD,$B*42",            0,   "",    1'b1, nsc_pkg::FAIL_OK},
        '{"+IPD$+IPD,$C*43",        0,   "",    1'b1, nsc_pkg::FAIL_OK},
        '{"+IPD,$A*141",            0,   "",    1'b1, nsc_pkg::FAIL_OK},
        '{"+IPD,$A*4G1",            0,   "",    1'b1, nsc_pkg::FAIL_MISMATCH},
        '{"+IPD,$A*4f",             0,   "",    1'b1, nsc_pkg::FAIL_MISMATCH},
        '{"+IPD,0,30:$GPGGA,1,2*5c\015\n", 0, "", 1'b0, nsc_pkg::FAIL_OK},
        '{"+IPD,$,X~*1a",           0,   "",    1'b0, nsc_pkg::FAIL_OK},
        '{"+IPD,$~,~*~",            0,   "",    1'b0, nsc_pkg::FAIL_OK},
        '{"+IPD,$",                 130, "*41", 1'b1, nsc_pkg::FAIL_UNTERM},
        '{"+IPD,$",                 121, "*",   1'b1, nsc_pkg::FAIL_MISMATCH},
        '{"+IPD,$N,",               15,  "*00", 1'b0, nsc_pkg::FAIL_OK}
    };

    logic [7:0] ipd_tag [nsc_pkg::TAG_LEN] = '{nsc_pkg::CH_PLUS, nsc_pkg::CH_I, nsc_pkg::CH_P,
                                               nsc_pkg::CH_D, nsc_pkg::CH_COMMA};
    logic [7:0] line_breaks [3] = '{nsc_pkg::CH_CR, nsc_pkg::CH_LF, nsc_pkg::CH_NUL};

    // Line scanner state of the predictor.
    nsc_pkg::phase_t              scan_phase;
    int                           tag_hits;
    int                           scan_pos;
    logic [7:0]                   xor_acc;
    logic [7:0]                   hex_acc;
    logic [nsc_pkg::FIELD_W-1:0]  name_start;
    logic [nsc_pkg::FIELD_W-1:0]  name_len;
    logic                         comma_hit;
    logic [nsc_pkg::FIELD_W-1:0]  detail_start;
    logic [nsc_pkg::FIELD_W-1:0]  detail_len;
    logic                         too_long;

    verdict_t pending_verdicts [$];
    verdict_t want;
    int       mismatches   = 0;
    int       results_seen = 0;
    int       cycles       = 0;
    int       stall_left   = 0;
    int       bytes_sent   = 0;
    int       random_lines = 0;

    function automatic logic [nsc_pkg::FIELD_W-1:0] clip_field(input int v);
        return (v > nsc_pkg::FIELD_MAX) ? nsc_pkg::FIELD_W'(nsc_pkg::FIELD_MAX)
                                        : nsc_pkg::FIELD_W'(v);
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - "0";
        if (c >= "a" && c <= "f") return int'(c) - "a" + 10;
        if (c >= "A" && c <= "F") return int'(c) - "A" + 10;
        return -1;
    endfunction

    function automatic void clear_scan();
        scan_phase   = nsc_pkg::PH_PREFIX;
        tag_hits     = 0;
        scan_pos     = 0;
        xor_acc      = '0;
        hex_acc      = '0;
        name_start   = '0;
        name_len     = '0;
        comma_hit    = 1'b0;
        detail_start = '0;
        detail_len   = '0;
        too_long     = 1'b0;
    endfunction

    // Folds one accepted byte into the line state; returns 1 with the verdict at line end.
    function automatic bit scan_byte(input logic [7:0] b, input bit last, output verdict_t v);
        int             d;
        nsc_pkg::fail_t code;
        v = '0;
        if (scan_pos >= nsc_pkg::LINE_LIMIT) begin
            too_long = 1'b1;
        end
        else begin
            case (scan_phase)
                nsc_pkg::PH_PREFIX:
                begin
                    if (tag_hits < nsc_pkg::TAG_LEN && b == ipd_tag[tag_hits])
                        tag_hits++;
                    else
                        tag_hits = (b == nsc_pkg::CH_PLUS) ? 1 : 0;
                    if (tag_hits >= nsc_pkg::TAG_LEN)
                        scan_phase = nsc_pkg::PH_DOLLAR;
                end
                nsc_pkg::PH_DOLLAR:
                begin
                    if (b == nsc_pkg::CH_DOLLAR)
                    begin
                        scan_phase = nsc_pkg::PH_BODY;
                        name_start = clip_field(scan_pos + 1);
                    end
                end
                nsc_pkg::PH_BODY:
                begin
                    if (b == nsc_pkg::CH_STAR)
                        scan_phase = nsc_pkg::PH_HEX;
                    else if (b == nsc_pkg::CH_CR || b == nsc_pkg::CH_LF
                             || b == nsc_pkg::CH_NUL)
                        scan_phase = nsc_pkg::PH_BROKEN;
                    else
                    begin
                        xor_acc = xor_acc ^ b;
                        if (comma_hit)
                            detail_len = clip_field(int'(detail_len) + 1);
                        else if (b == nsc_pkg::CH_COMMA)
                        begin
                            comma_hit    = 1'b1;
                            detail_start = clip_field(scan_pos + 1);
                        end
                        else
                            name_len = clip_field(int'(name_len) + 1);
                    end
                end
                nsc_pkg::PH_HEX:
                begin
                    d = hex_nibble(b);
                    if (d < 0)
                        scan_phase = nsc_pkg::PH_DONE;
                    else
                        hex_acc = {hex_acc[3:0], 4'(d)};
                end
                default:
                begin
                end
            endcase
            scan_pos++;
        end
        if (!last)
            return 1'b0;
        if (too_long)
            code = nsc_pkg::FAIL_UNTERM;
        else if (scan_phase == nsc_pkg::PH_PREFIX)
            code = nsc_pkg::FAIL_NO_PREFIX;
        else if (scan_phase == nsc_pkg::PH_DOLLAR)
            code = nsc_pkg::FAIL_NO_DOLLAR;
        else if (scan_phase == nsc_pkg::PH_BODY || scan_phase == nsc_pkg::PH_BROKEN)
            code = nsc_pkg::FAIL_UNTERM;
        else if (xor_acc == 8'h00)
            code = nsc_pkg::FAIL_ZERO_SUM;
        else if (hex_acc != xor_acc)
            code = nsc_pkg::FAIL_MISMATCH;
        else
            code = nsc_pkg::FAIL_OK;
        v.ok    = (code == nsc_pkg::FAIL_OK);
        v.code  = code;
        v.csum  = xor_acc;
        v.rsum  = hex_acc;
        v.noff  = name_start;
        v.nlen  = name_len;
        v.dpres = comma_hit;
        v.doff  = comma_hit ? detail_start : '0;
        v.dlen  = comma_hit ? detail_len : '0;
        clear_scan();
        return 1'b1;
    endfunction

    function automatic void push_text(ref byte_q_t q, input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c == "~")
                c = 8'hFF;
            else if (c == "#")
                c = nsc_pkg::CH_NUL;
            q.push_back(c);
        end
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        return (c == nsc_pkg::CH_STAR) ? 8'h2E : c;
    endfunction

    function automatic logic [7:0] name_char();
        int r;
        r = $urandom_range(0, 35);
        return (r < 26) ? 8'("A" + r) : 8'("0" + r - 26);
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return 8'("0" + n);
        return upper ? 8'("A" + n - 10) : 8'("a" + n - 10);
    endfunction

    // Mostly well-formed sentences with random content; the rest broken or plain noise.
    function automatic void make_line(output byte_q_t q);
        int         kind;
        int         n;
        int         cut;
        logic [7:0] c;
        logic [7:0] sum;
        logic [7:0] tx;
        bit         upper;
        q = {};
        kind = $urandom_range(0, 99);
        if (kind >= 85 && kind < 95)
        begin
            n = $urandom_range(1, 24);
            repeat (n) q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        n = $urandom_range(0, 3);
        repeat (n) q.push_back(text_char());
        if ($urandom_range(0, 5) == 0)
            push_text(q, "+IP");
        push_text(q, "+IPD,");
        if ($urandom_range(0, 1) == 1)
            push_text(q, "0,42:");
        q.push_back(nsc_pkg::CH_DOLLAR);
        sum = '0;
        n = (kind >= 95) ? $urandom_range(20, 90) : $urandom_range(1, 6);
        repeat (n)
        begin
            c = name_char();
            sum ^= c;
            q.push_back(c);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            sum ^= nsc_pkg::CH_COMMA;
            q.push_back(nsc_pkg::CH_COMMA);
            n = (kind >= 95) ? $urandom_range(40, 110) : $urandom_range(0, 14);
            repeat (n)
            begin
                c = text_char();
                sum ^= c;
                q.push_back(c);
            end
        end
        q.push_back(nsc_pkg::CH_STAR);
        tx = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : sum;
        upper = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0:
                q.push_back(nibble_char(tx[3:0], upper));
            1:
            begin
                q.push_back(nibble_char(4'($urandom_range(0, 15)), upper));
                q.push_back(nibble_char(tx[7:4], upper));
                q.push_back(nibble_char(tx[3:0], upper));
            end
            2:
            begin
            end
            default:
            begin
                q.push_back(nibble_char(tx[7:4], upper));
                q.push_back(nibble_char(tx[3:0], upper));
            end
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            q.push_back(nsc_pkg::CH_CR);
            q.push_back(nsc_pkg::CH_LF);
        end
        if (kind >= 70 && kind < 85)
        begin
            cut = $urandom_range(0, q.size() - 1);
            case ($urandom_range(0, 2))
                0:
                    while (q.size() > cut + 1) void'(q.pop_back());
                1:
                    q[cut] = line_breaks[$urandom_range(0, 2)];
                default:
                    q[cut] = 8'($urandom_range(0, 255));
            endcase
        end
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("result %0d: %s", results_seen, msg);
    endtask

    task automatic check_field(input string fname, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (got_v !== exp_v)
            note_error($sformatf("%s expected %0h, got %0h", fname, exp_v, got_v));
    endtask

    // Sends one line byte by byte; the verdict is queued when its last byte is taken.
    task automatic send_line(input byte_q_t q, input bit typed, input nsc_pkg::fail_t code);
        int       gap;
        bit       quiet;
        verdict_t v;
        quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < q.size(); i++)
        begin
            gap = pick_gap(quiet);
            if (gap > 0)
            begin
                line_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            line_valid <= 1'b1;
            line_byte  <= q[i];
            line_last  <= (i == q.size() - 1);
            @(posedge clk);
            while (line_stall) @(posedge clk);
            bytes_sent++;
            if (scan_byte(q[i], i == q.size() - 1, v))
            begin
                if (typed)
                begin
                    v.code = code;
                    v.ok   = (code == nsc_pkg::FAIL_OK);
                end
                pending_verdicts.push_back(v);
            end
        end
    endtask

    initial
    begin
        byte_q_t q;
        clear_scan();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[r])
        begin
            q = {};
            push_text(q, directed_rows[r].head);
            repeat (directed_rows[r].fill) q.push_back(8'h41);
            push_text(q, directed_rows[r].tail);
            send_line(q, directed_rows[r].typed, directed_rows[r].code);
        end
        while (bytes_sent < 640 || random_lines < 4)
        begin
            make_line(q);
            send_line(q, 1'b0, nsc_pkg::FAIL_OK);
            random_lines++;
        end
        line_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("[nmea_sentence_checker] OK");
        else
            $display("[nmea_sentence_checker] ERROR");
        $finish;
    end

    // Receiver back-pressure: free-running stretches, short stalls and a few long ones.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7:
                begin
                    result_stall <= 1'b0;
                    stall_left   <= $urandom_range(1, 20);
                end
                8, 9, 10, 11, 12, 13, 14, 15:
                begin
                    result_stall <= 1'b1;
                    stall_left   <= $urandom_range(1, 3);
                end
                16, 17:
                begin
                    result_stall <= 1'b1;
                    stall_left   <= $urandom_range(10, 40);
                end
                default:
                begin
                    result_stall <= 1'b0;
                    stall_left   <= $urandom_range(50, 150);
                end
            endcase
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_verdicts.size() == 0)
            begin
                note_error("result arrived with no line pending");
            end
            else
            begin
                want = pending_verdicts.pop_front();
                check_field("sentence_ok", want.ok, sentence_ok);
                check_field("fail_code", want.code, fail_code);
                check_field("computed_sum", want.csum, computed_sum);
                check_field("received_sum", want.rsum, received_sum);
                check_field("name_offset", want.noff, name_offset);
                check_field("name_length", want.nlen, name_length);
                check_field("detail_present", want.dpres, detail_present);
                check_field("detail_offset", want.doff, detail_offset);
                check_field("detail_length", want.dlen, detail_length);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[nmea_sentence_checker] ERROR");
            $finish;
        end
    end

endmodule

// File: nmea_sentence_checker.f
rtl/nsc_pkg.sv
rtl/nmea_sentence_checker.sv
rtl/nsc_checker.sv
tb/sv/tb_nmea_sentence_checker.sv
